// ===== hw/rtl/bdpc_pkg.sv =====
// Types and constants shared by the button debounce and press classifier.
`default_nettype none

package bdpc_pkg;

	localparam int ACTION_W = 2;
	localparam int EVENT_W  = 2;
	localparam int NOW_W    = 32;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE   = 2'd0,
		ACT_WAKE     = 2'd1,
		ACT_SUPPRESS = 2'd2,
		ACT_CLEAR    = 2'd3
	} action_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_TAP_MIN    = 3'd1,
		REG_LONG_PRESS = 3'd2,
		REG_REPEAT_GAP = 3'd3,
		REG_LONG_EN    = 3'd4
	} reg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] TAP_MIN_RST    = 16'd30;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] REPEAT_GAP_RST = 16'd0;
	localparam logic             LONG_EN_RST    = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/button_debounce_press_classifier.sv =====
// Top level: debounce of one active-low button with short, long and repeat press events.
`default_nettype none

// One word in gives one word out. The block takes a word every cycle unless a full
// output register is held by a low out_ready. The word is registered, then a single pass
// of wrap-around subtract and compare against the stored button state decides the event
// and the next state, and the result lands in an output register. That single
// subtract-compare pass on TIME_BITS-wide timestamps sets the clock period. Timestamps are
// kept modulo 2^TIME_BITS. Write configuration only while no word is in flight.
module button_debounce_press_classifier #(
	parameter int TIME_BITS = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [bdpc_pkg::ACTION_W-1:0]        action,
	input  wire                                  pin_level,
	input  wire  [bdpc_pkg::NOW_W-1:0]           now_ms,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [bdpc_pkg::EVENT_W-1:0]         event_res,
	output logic                                 pressed_now,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [bdpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [bdpc_pkg::CFG_W-1:0]           cfg_data
);
	import bdpc_pkg::*;

	typedef logic [TIME_BITS-1:0] tstamp_t;

	logic [CFG_W-1:0] debounce_q, tap_min_q, long_press_q, repeat_gap_q;
	logic             long_en_q;

	logic    valid_s1;
	action_t action_s1;
	logic    pin_s1;
	tstamp_t now_s1;

	logic    stable_q, last_raw_q, long_fired_q, supp_active_q, supp_started_q;
	tstamp_t deb_start_q, press_start_q, last_long_q, supp_start_q;

	logic    stable_d, last_raw_d, long_fired_d, supp_active_d, supp_started_d;
	tstamp_t deb_start_d, press_start_d, last_long_d, supp_start_d;
	event_t  ev_d;

	logic    out_valid_q;
	event_t  event_q;
	logic    pressed_q;

	logic                    advance;
	logic [TIME_BITS+NOW_W-1:0] now_ext;
	tstamp_t                 now_in;

	tstamp_t deb_elapsed, supp_elapsed, tap_elapsed, hold_elapsed, rep_elapsed;
	tstamp_t deb_lim, tap_lim, long_lim, rep_lim;
	logic    deb_ok, short_hit;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign now_ext = {{TIME_BITS{1'b0}}, now_ms};
	assign now_in  = now_ext[TIME_BITS-1:0];

	assign deb_lim  = TIME_BITS'(debounce_q);
	assign tap_lim  = TIME_BITS'(tap_min_q);
	assign long_lim = TIME_BITS'(long_press_q);
	assign rep_lim  = TIME_BITS'(repeat_gap_q);

	assign deb_elapsed  = now_s1 - deb_start_q;
	assign supp_elapsed = now_s1 - supp_start_q;
	assign tap_elapsed  = now_s1 - press_start_q;
	assign rep_elapsed  = now_s1 - last_long_q;

	assign deb_ok = (pin_s1 == last_raw_q) && (deb_elapsed > deb_lim);

	always_comb begin
		stable_d       = stable_q;
		last_raw_d     = last_raw_q;
		long_fired_d   = long_fired_q;
		supp_active_d  = supp_active_q;
		supp_started_d = supp_started_q;
		deb_start_d    = deb_start_q;
		press_start_d  = press_start_q;
		last_long_d    = last_long_q;
		supp_start_d   = supp_start_q;
		ev_d           = EV_NONE;
		short_hit      = 1'b0;
		hold_elapsed   = '0;
		case (action_s1)
			ACT_SAMPLE: begin
				if (supp_active_q) begin
					if (!pin_s1) begin
						supp_started_d = 1'b0;
						supp_start_d   = '0;
						last_raw_d     = 1'b0;
						stable_d       = 1'b0;
					end else if (!supp_started_q) begin
						supp_started_d = 1'b1;
						supp_start_d   = now_s1;
					end else if (supp_elapsed > deb_lim) begin
						supp_active_d  = 1'b0;
						supp_started_d = 1'b0;
						supp_start_d   = '0;
						stable_d       = 1'b1;
						last_raw_d     = 1'b1;
						press_start_d  = '0;
						last_long_d    = '0;
						long_fired_d   = 1'b0;
						deb_start_d    = now_s1;
					end
				end else begin
					if (pin_s1 != last_raw_q) begin
						deb_start_d = now_s1;
					end
					if (deb_ok && (pin_s1 != stable_q)) begin
						stable_d = pin_s1;
						if (!pin_s1) begin
							press_start_d = now_s1;
							long_fired_d  = 1'b0;
						end else if (!stable_q && !long_fired_q) begin
							press_start_d = '0;
							short_hit     = tap_elapsed > tap_lim;
						end
					end
					if (short_hit) begin
						ev_d = EV_SHORT;
					end else begin
						last_raw_d   = pin_s1;
						hold_elapsed = now_s1 - press_start_d;
						if (long_en_q && !pin_s1 && !stable_d) begin
							if (!long_fired_d && (hold_elapsed > long_lim)) begin
								long_fired_d = 1'b1;
								last_long_d  = now_s1;
								ev_d         = EV_LONG;
							end else if (long_fired_d && (repeat_gap_q != '0) &&
									(rep_elapsed >= rep_lim)) begin
								last_long_d = now_s1;
								ev_d        = EV_LONG;
							end
						end
					end
				end
			end
			ACT_WAKE: begin
				if (!pin_s1) begin
					stable_d      = 1'b0;
					last_raw_d    = 1'b0;
					press_start_d = now_s1;
					last_long_d   = '0;
					long_fired_d  = 1'b0;
					deb_start_d   = now_s1;
				end
			end
			ACT_SUPPRESS: begin
				supp_active_d  = 1'b1;
				supp_started_d = 1'b0;
				supp_start_d   = '0;
			end
			ACT_CLEAR: begin
				stable_d      = 1'b1;
				last_raw_d    = 1'b1;
				press_start_d = '0;
				last_long_d   = '0;
				long_fired_d  = 1'b0;
				deb_start_d   = now_s1;
			end
			default: begin
				ev_d = EV_NONE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			tap_min_q    <= TAP_MIN_RST;
			long_press_q <= LONG_PRESS_RST;
			repeat_gap_q <= REPEAT_GAP_RST;
			long_en_q    <= LONG_EN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_TAP_MIN:    tap_min_q    <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_REPEAT_GAP: repeat_gap_q <= cfg_data;
				REG_LONG_EN:    long_en_q    <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action_t'(action);
			pin_s1    <= pin_level;
			now_s1    <= now_in;
		end
	end

	// button state, advance once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q       <= 1'b1;
			last_raw_q     <= 1'b1;
			long_fired_q   <= 1'b0;
			supp_active_q  <= 1'b0;
			supp_started_q <= 1'b0;
			deb_start_q    <= '0;
			press_start_q  <= '0;
			last_long_q    <= '0;
			supp_start_q   <= '0;
		end else if (advance) begin
			stable_q       <= stable_d;
			last_raw_q     <= last_raw_d;
			long_fired_q   <= long_fired_d;
			supp_active_q  <= supp_active_d;
			supp_started_q <= supp_started_d;
			deb_start_q    <= deb_start_d;
			press_start_q  <= press_start_d;
			last_long_q    <= last_long_d;
			supp_start_q   <= supp_start_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= ev_d;
			pressed_q <= !pin_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = event_q;
	assign pressed_now = pressed_q;

	a_supp_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && supp_active_q |=> event_res == EV_NONE)
		else $error("event produced while suppressed");

	a_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pressed_now == !$past(pin_s1))
		else $error("pressed_now does not follow the pin");

	a_long_off: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !long_en_q |=> event_res != EV_LONG)
		else $error("long event while long events disabled");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output");

endmodule

`default_nettype wire

// ===== tb/sv/tb_button_debounce_press_classifier.sv =====
// Testbench for the button debouncer: directed and random polled samples checked against a predictor.
`default_nettype none

module tb_button_debounce_press_classifier;

	timeunit 1ns;
	timeprecision 1ps;

	import bdpc_pkg::*;

	typedef struct packed {
		event_t ev;
		logic   pressed;
	} press_report_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action      = ACT_SAMPLE;
	logic                 pin_level   = 1'b1;
	logic [NOW_W-1:0]     now_ms      = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [EVENT_W-1:0]   event_res;
	logic                 pressed_now;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_DEBOUNCE;
	logic [CFG_W-1:0]     cfg_data    = '0;

	button_debounce_press_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pin_level   (pin_level),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.pressed_now (pressed_now),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// predictor copy of the registers and the button state
	logic [CFG_W-1:0] dbn_ms, tap_ms, long_ms, gap_ms;
	logic             long_on;
	logic             dbn_level, raw_prev, long_done, sup_on, sup_armed;
	logic [NOW_W-1:0] bounce_t0, hold_t0, long_t, sup_t0;

	press_report_t    reports_due[$];
	int unsigned      errors      = 0;
	int unsigned      words_sent  = 0;
	int unsigned      hold_req    = 0;
	bit               idle_on     = 1'b1;
	logic [NOW_W-1:0] clock_ms    = '0;

	function automatic void predictor_reset();
		dbn_ms    = DEBOUNCE_RST;
		tap_ms    = TAP_MIN_RST;
		long_ms   = LONG_PRESS_RST;
		gap_ms    = REPEAT_GAP_RST;
		long_on   = LONG_EN_RST;
		dbn_level = 1'b1;
		raw_prev  = 1'b1;
		bounce_t0 = '0;
		hold_t0   = '0;
		long_t    = '0;
		long_done = 1'b0;
		sup_on    = 1'b0;
		sup_armed = 1'b0;
		sup_t0    = '0;
	endfunction

	function automatic void release_all(logic [NOW_W-1:0] t);
		dbn_level = 1'b1;
		raw_prev  = 1'b1;
		hold_t0   = '0;
		long_t    = '0;
		long_done = 1'b0;
		bounce_t0 = t;
	endfunction

	function automatic event_t classify(action_t a, logic pin, logic [NOW_W-1:0] t);
		logic [NOW_W-1:0] d;
		case (a)
			ACT_WAKE: begin
				if (!pin) begin
					dbn_level = 1'b0;
					raw_prev  = 1'b0;
					hold_t0   = t;
					long_t    = '0;
					long_done = 1'b0;
					bounce_t0 = t;
				end
				return EV_NONE;
			end
			ACT_SUPPRESS: begin
				sup_on    = 1'b1;
				sup_armed = 1'b0;
				sup_t0    = '0;
				return EV_NONE;
			end
			ACT_CLEAR: begin
				release_all(t);
				return EV_NONE;
			end
			default: ;
		endcase
		if (sup_on) begin
			if (!pin) begin
				sup_armed = 1'b0;
				sup_t0    = '0;
				raw_prev  = 1'b0;
				dbn_level = 1'b0;
			end else if (!sup_armed) begin
				sup_armed = 1'b1;
				sup_t0    = t;
			end else begin
				d = t - sup_t0;
				if (d > dbn_ms) begin
					sup_on    = 1'b0;
					sup_armed = 1'b0;
					sup_t0    = '0;
					release_all(t);
				end
			end
			return EV_NONE;
		end
		if (pin != raw_prev)
			bounce_t0 = t;
		d = t - bounce_t0;
		if (d > dbn_ms && pin != dbn_level) begin
			dbn_level = pin;
			if (!pin) begin
				hold_t0   = t;
				long_done = 1'b0;
			end else if (!long_done) begin
				d       = t - hold_t0;
				hold_t0 = '0;
				if (d > tap_ms)
					return EV_SHORT;
			end
		end
		raw_prev = pin;
		if (!long_on || pin || dbn_level)
			return EV_NONE;
		d = t - hold_t0;
		if (!long_done && d > long_ms) begin
			long_done = 1'b1;
			long_t    = t;
			return EV_LONG;
		end
		d = t - long_t;
		if (long_done && gap_ms != 0 && d >= gap_ms) begin
			long_t = t;
			return EV_LONG;
		end
		return EV_NONE;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		errors++;
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	task automatic send_word(action_t a, logic pin, logic [NOW_W-1:0] t);
		int unsigned gap;
		press_report_t r;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		action    <= a;
		pin_level <= pin;
		now_ms    <= t;
		do @(posedge clk); while (!in_ready);
		r.ev      = classify(a, pin, t);
		r.pressed = !pin;
		reports_due.push_back(r);
		words_sent++;
	endtask

	task automatic poll(logic pin, int unsigned dt);
		clock_ms = clock_ms + dt;
		send_word(ACT_SAMPLE, pin, clock_ms);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE:   dbn_ms  = val;
			REG_TAP_MIN:    tap_ms  = val;
			REG_LONG_PRESS: long_ms = val;
			REG_REPEAT_GAP: gap_ms  = val;
			REG_LONG_EN:    long_on = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(logic [CFG_W-1:0] d, logic [CFG_W-1:0] tap,
			logic [CFG_W-1:0] lp, logic [CFG_W-1:0] g, bit en);
		wait_drained();
		write_reg(REG_DEBOUNCE, d);
		write_reg(REG_TAP_MIN, tap);
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_REPEAT_GAP, g);
		write_reg(REG_LONG_EN, {15'd0, en});
	endtask

	task automatic bounce(logic lvl);
		repeat ($urandom_range(0, 3)) begin
			poll(lvl, $urandom_range(0, 2));
			poll(!lvl, $urandom_range(0, 2));
		end
	endtask

	task automatic press_cycle();
		int unsigned step, hold_ms, n;
		case ($urandom_range(0, 2))
			0: hold_ms = $urandom_range(0, dbn_ms + tap_ms + 2);
			1: hold_ms = dbn_ms + $urandom_range(0, long_ms + 2);
			default: hold_ms = dbn_ms + long_ms + $urandom_range(1, 4 * gap_ms + 4);
		endcase
		step = $urandom_range(1, dbn_ms / 4 + 8);
		if (hold_ms / step > 30)
			step = hold_ms / 30 + 1;
		n = hold_ms / step + 1;
		if ($urandom_range(0, 7) == 0)
			send_word(ACT_WAKE, 1'b0, clock_ms + 1);
		bounce(1'b0);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				send_word(action_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
					clock_ms);
			poll($urandom_range(0, 24) != 0 ? 1'b0 : 1'b1, step);
		end
		bounce(1'b1);
		step = dbn_ms / 6 + 1;
		repeat (8) poll(1'b1, step);
	endtask

	task automatic suppress_cycle();
		send_word(ACT_SUPPRESS, 1'($urandom_range(0, 1)), clock_ms);
		repeat ($urandom_range(0, 3))
			poll(1'($urandom_range(0, 1)), $urandom_range(0, dbn_ms + 2));
		repeat (8) poll(1'b1, dbn_ms / 6 + 1);
	endtask

	task automatic noise_word();
		if ($urandom_range(0, 9) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, 2 * dbn_ms + 10);
		send_word(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), clock_ms);
	endtask

	task automatic run_mix(int unsigned words);
		int unsigned start, r;
		start = words_sent;
		while (words_sent - start < words) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				press_cycle();
			else if (r < 8)
				suppress_cycle();
			else
				noise_word();
		end
	endtask

	task automatic test_directed_cases();
		send_word(ACT_SAMPLE,   1'b1, 32'd0);
		send_word(ACT_SAMPLE,   1'b0, 32'd10);
		send_word(ACT_SAMPLE,   1'b0, 32'd61);
		send_word(ACT_SAMPLE,   1'b0, 32'd1062);
		send_word(ACT_SAMPLE,   1'b0, 32'd2000);
		send_word(ACT_SAMPLE,   1'b1, 32'd2010);
		send_word(ACT_SAMPLE,   1'b1, 32'd2061);
		send_word(ACT_SAMPLE,   1'b0, 32'd3000);
		send_word(ACT_SAMPLE,   1'b0, 32'd3051);
		send_word(ACT_SAMPLE,   1'b1, 32'd3100);
		send_word(ACT_SAMPLE,   1'b1, 32'd3151);
		send_word(ACT_SAMPLE,   1'b1, 32'd3160);
		send_word(ACT_WAKE,     1'b1, 32'd3200);
		send_word(ACT_WAKE,     1'b0, 32'hFFFF_FFF0);
		send_word(ACT_SAMPLE,   1'b0, 32'h0000_0400);
		send_word(ACT_SUPPRESS, 1'b0, 32'h0000_0500);
		send_word(ACT_SAMPLE,   1'b0, 32'h0000_0510);
		send_word(ACT_SAMPLE,   1'b1, 32'h0000_0520);
		send_word(ACT_SAMPLE,   1'b1, 32'h0000_0560);
		send_word(ACT_CLEAR,    1'b0, 32'h0000_0600);
		send_word(ACT_CLEAR,    1'b1, 32'hFFFF_FFFF);
		send_word(ACT_SAMPLE,   1'b0, 32'h0000_0000);
		send_word(ACT_SAMPLE,   1'b1, 32'h7FFF_FFFF);
		clock_ms = 32'h8000_0000;
	endtask

	task automatic test_register_extremes();
		write_all(0, 0, 0, 1, 1'b1);
		run_mix(60);
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		run_mix(50);
		write_all(20, 5, 200, 50, 1'b0);
		run_mix(50);
		write_all(10, 15, 100, 7, 1'b1);
		run_mix(70);
		write_all(CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(0, 100)),
			CFG_W'($urandom_range(0, 500)), CFG_W'($urandom_range(0, 60)),
			1'($urandom_range(0, 1)));
		run_mix(50);
	endtask

	task automatic test_press_sequences();
		write_all(DEBOUNCE_RST, TAP_MIN_RST, LONG_PRESS_RST, 120, LONG_EN_RST);
		run_mix(100);
		idle_on = 1'b0;
		run_mix(40);
		idle_on = 1'b1;
	endtask

	task automatic test_output_stall();
		wait_drained();
		idle_on  = 1'b0;
		hold_req = 300;
		run_mix(40);
		wait_drained();
		idle_on = 1'b1;
	endtask

	initial begin : result_sink
		int unsigned left;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				left     = hold_req;
				hold_req = 0;
			end else if (left == 0) begin
				left = pick_gap();
			end
			if (left != 0) begin
				out_ready <= 1'b0;
				left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		press_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reports_due.size() == 0) begin
				report("unexpected word", 32'(event_res), 0);
			end else begin
				want = reports_due.pop_front();
				if (event_res !== want.ev)
					report("event_res", 32'(event_res), 32'(want.ev));
				if (pressed_now !== want.pressed)
					report("pressed_now", 32'(pressed_now), 32'(want.pressed));
			end
		end
	end

	initial begin
		predictor_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_register_extremes();
		test_press_sequences();
		test_output_stall();
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/bdpc_pkg.sv
hw/rtl/button_debounce_press_classifier.sv
tb/sv/tb_button_debounce_press_classifier.sv
